>>> src/dpd_pkg.sv
// Package for the deadband proportional drive with pulse dithering.
// Widths, register indexes, controller states and the command struct.
// No dependencies; every other file uses it by scoped names.
package dpd_pkg;

	// Field and register widths
	localparam int ERROR_WIDTH = 11;
	localparam int GAIN_W      = 16;
	localparam int SCALE_W     = 16;
	localparam int DB_W        = 10;
	localparam int LIM_W       = 15;
	localparam int MP_W        = 15;
	localparam int DRIVE_W     = 16;
	localparam int RES_W       = 17;

	// Product of gain and error, also the dividend and quotient width
	localparam int PROD_W = GAIN_W + ERROR_WIDTH;
	// Step counter of the divider
	localparam int CNT_W  = $clog2(PROD_W);

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DEADBAND  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_PULSE = 3'd4;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_LOAD,
		ST_DIV,
		ST_DONE
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic cap;     // capture the error sample
		logic mul;     // register gain * error
		logic load;    // load product magnitude into the divider
		logic step;    // one restoring division step
		logic finish;  // resolve drive and residual, load output register
	} cmd_t;

endpackage

>>> src/dpd_if.sv
// Stream interfaces for the error samples and the drive results.
// Depends on dpd_pkg for the payload widths.
interface dpd_err_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [dpd_pkg::ERROR_WIDTH-1:0] error;

	modport source (output valid, output error, input ready);
	modport sink   (input valid, input error, output ready);
endinterface

interface dpd_drive_if;
	logic                               valid;
	logic                               ready;
	logic signed [dpd_pkg::DRIVE_W-1:0] drive;

	modport source (output valid, output drive, input ready);
	modport sink   (input valid, input drive, output ready);
endinterface

>>> src/dpd_ctrl.sv
// Controller of the deadband drive: sequences capture, multiply, division
// and the final resolve, and owns the handshake flags. Depends on dpd_pkg.
module dpd_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output dpd_pkg::cmd_t cmd
);

	localparam logic [dpd_pkg::CNT_W-1:0] LAST_STEP = dpd_pkg::CNT_W'(dpd_pkg::PROD_W - 1);

	dpd_pkg::state_t             state_q, state_d;
	logic [dpd_pkg::CNT_W-1:0]   cnt_q;
	logic                        out_valid_q;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dpd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			dpd_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.cap = 1'b1;
					state_d = dpd_pkg::ST_MUL;
				end
			end
			dpd_pkg::ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = dpd_pkg::ST_LOAD;
			end
			dpd_pkg::ST_LOAD: begin
				cmd.load = 1'b1;
				state_d  = dpd_pkg::ST_DIV;
			end
			dpd_pkg::ST_DIV: begin
				cmd.step = 1'b1;
				if (cnt_q == LAST_STEP) begin
					state_d = dpd_pkg::ST_DONE;
				end
			end
			dpd_pkg::ST_DONE: begin
				// wait for the output register to be free
				if (!out_valid_q || out_ready) begin
					cmd.finish = 1'b1;
					state_d    = dpd_pkg::ST_IDLE;
				end
			end
			default: state_d = dpd_pkg::ST_IDLE;
		endcase
	end

	// Division step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load) begin
			cnt_q <= '0;
		end else if (cmd.step) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// Output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	// Division runs exactly PROD_W steps, then resolves
	a_div_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dpd_pkg::ST_DIV && cnt_q == LAST_STEP) |=> state_q == dpd_pkg::ST_DONE)
		else $error("divider did not end after its last step");

	// An accepted sample starts the multiply
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> state_q == dpd_pkg::ST_MUL)
		else $error("accepted sample did not start the multiply");

	// A new result appears only out of the resolve state
	a_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == dpd_pkg::ST_DONE)
		else $error("result valid rose outside the resolve state");

	// No pending result is overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!out_valid_q || out_ready))
		else $error("pending result overwritten");

endmodule

>>> src/dpd_dp.sv
// Datapath of the deadband drive: configuration registers, multiplier,
// restoring divider, clamp, dither residual and output register. Depends on dpd_pkg.
module dpd_dp (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  dpd_pkg::cmd_t                          cmd,
	input  logic signed [dpd_pkg::ERROR_WIDTH-1:0] error,
	input  logic                                   wr_en,
	input  logic [dpd_pkg::CFG_IDX_W-1:0]          wr_index,
	input  logic [dpd_pkg::CFG_DATA_W-1:0]         wr_data,
	output logic signed [dpd_pkg::DRIVE_W-1:0]     drive
);

	localparam int EW  = dpd_pkg::ERROR_WIDTH;
	localparam int PW  = dpd_pkg::PROD_W;
	localparam int SW  = dpd_pkg::SCALE_W;
	localparam int DW  = dpd_pkg::DRIVE_W;
	localparam int RW  = dpd_pkg::RES_W;
	localparam int LW  = dpd_pkg::LIM_W;
	localparam int CMP_W = 17;

	// Configuration registers
	logic signed [dpd_pkg::GAIN_W-1:0] gain_q;
	logic [SW-1:0]                     scale_q;
	logic [dpd_pkg::DB_W-1:0]          db_q;
	logic [LW-1:0]                     lim_q;
	logic [dpd_pkg::MP_W-1:0]          mp_q;

	// Working registers
	logic signed [EW-1:0] err_q;
	logic signed [PW-1:0] product_q;
	logic [PW-1:0]        dvd_q;
	logic [SW-1:0]        rem_q;
	logic signed [RW-1:0] residual_q;
	logic signed [DW-1:0] drive_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q  <= '0;
			scale_q <= SW'(1);
			db_q    <= '0;
			lim_q   <= '1;
			mp_q    <= '0;
		end else if (wr_en) begin
			case (wr_index)
				dpd_pkg::REG_GAIN:      gain_q  <= wr_data;
				dpd_pkg::REG_SCALE:     scale_q <= wr_data;
				dpd_pkg::REG_DEADBAND:  db_q    <= wr_data[dpd_pkg::DB_W-1:0];
				dpd_pkg::REG_LIMIT:     lim_q   <= wr_data[LW-1:0];
				dpd_pkg::REG_MIN_PULSE: mp_q    <= wr_data[dpd_pkg::MP_W-1:0];
				default: ;
			endcase
		end
	end

	// Multiplier operands, sign extended to the product width
	logic signed [PW-1:0] gain_x, err_x;
	logic [PW-1:0]        prod_mag;
	assign gain_x   = PW'(gain_q);
	assign err_x    = PW'(err_q);
	assign prod_mag = product_q[PW-1] ? PW'(~product_q + 1'b1) : PW'(product_q);

	// Restoring division step
	logic [SW:0] shifted, diff;
	logic        q_bit;
	assign shifted = {rem_q, dvd_q[PW-1]};
	assign q_bit   = shifted >= {1'b0, scale_q};
	assign diff    = shifted - {1'b0, scale_q};

	// Resolve: deadband, clamp, pulse dithering
	logic [EW-1:0]        err_mag;
	logic                 in_db, zero_div, demand_neg, d_zero, big_demand, r_over, r_pos;
	logic [LW-1:0]        qc;
	logic signed [DW-1:0] d_pos, d;
	logic signed [RW:0]   r_sum, p_pos, pulse, r_next;
	logic [RW:0]          r_mag;

	always_comb begin
		err_mag    = err_q[EW-1] ? EW'(~err_q + 1'b1) : EW'(err_q);
		in_db      = CMP_W'(err_mag) <= CMP_W'(db_q);
		zero_div   = scale_q == '0;
		// demand = -product / scale
		demand_neg = ~product_q[PW-1];
		qc         = (dvd_q > PW'(lim_q)) ? lim_q : dvd_q[LW-1:0];
		d_pos      = DW'({1'b0, qc});
		d          = demand_neg ? -d_pos : d_pos;
		d_zero     = qc == '0;
		big_demand = qc >= mp_q;
		r_sum      = (RW+1)'(residual_q) + (RW+1)'(d);
		r_mag      = r_sum[RW] ? (RW+1)'(-r_sum) : (RW+1)'(r_sum);
		r_over     = r_mag >= (RW+1)'(mp_q);
		r_pos      = !r_sum[RW] && (r_sum != '0);
		p_pos      = (RW+1)'(mp_q);
		pulse      = r_pos ? p_pos : -p_pos;
		r_next     = r_sum - pulse;
	end

	// Sample, product and divider registers
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			err_q <= error;
		end
		if (cmd.mul) begin
			product_q <= gain_x * err_x;
		end
		if (cmd.load) begin
			dvd_q <= prod_mag;
			rem_q <= '0;
		end else if (cmd.step) begin
			dvd_q <= {dvd_q[PW-2:0], q_bit};
			rem_q <= q_bit ? diff[SW-1:0] : shifted[SW-1:0];
		end
	end

	// Dither residual
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			residual_q <= '0;
		end else if (cmd.finish && !zero_div) begin
			if (in_db || d_zero || big_demand) begin
				residual_q <= '0;
			end else if (r_over) begin
				residual_q <= r_next[RW-1:0];
			end else begin
				residual_q <= r_sum[RW-1:0];
			end
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			if (zero_div || in_db || d_zero) begin
				drive_q <= '0;
			end else if (big_demand) begin
				drive_q <= d;
			end else if (r_over) begin
				drive_q <= pulse[DW-1:0];
			end else begin
				drive_q <= '0;
			end
		end
	end

	assign drive = drive_q;

	// A zero divisor leaves the residual alone
	a_zero_div: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.finish && scale_q == '0) |=> $stable(residual_q))
		else $error("residual changed with zero divisor");

	// Residual never reaches the most negative code
	a_res_range: assert property (@(posedge clk) disable iff (!arst_n)
		residual_q != {1'b1, {(RW-1){1'b0}}})
		else $error("residual out of range");

	// Without a pulse, a sum below min pulse is kept as the new residual
	a_res_below: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.finish && !zero_div && !in_db && !d_zero && !big_demand && !r_over)
		|=> residual_q == $past(r_sum[RW-1:0]))
		else $error("residual not accumulated");

endmodule

>>> src/deadband_p_drive_dither.sv
// Deadband proportional drive with pulse dithering, top level.
// Channel sample carries one signed error per control step; channel result
// returns one signed drive per sample; both use valid/ready, a transaction
// completing on a clock edge with valid and ready high.
// Registers (gain, scale_divisor, deadband, output_limit, min_pulse) are written
// through wr_en / wr_index / wr_data; the user must write them only while the
// block is idle, which the block itself does not enforce.
// A taken sample passes through the multiply, the divider load, the division
// steps on a PROD_W-bit product (gain width plus error width) and the resolve;
// the restoring divider that scales the gain product yields one bit per cycle.
// The block takes one sample at a time: sample.ready is high only while idle.
// A result waiting in the output register does not stop the next sample from
// being taken; if the receiver still stalls when that sample is resolved, the
// block holds in its resolve state until the result register frees up.
// Reset: asynchronous active-low arst_n restores the register defaults,
// clears the dither residual and drops result.valid.
// Depends on dpd_pkg, dpd_if, dpd_ctrl and dpd_dp.
module deadband_p_drive_dither (
	input  logic                                clk,
	input  logic                                arst_n,
	dpd_err_if.sink                             sample,
	dpd_drive_if.source                         result,
	input  logic                                wr_en,
	input  logic [dpd_pkg::CFG_IDX_W-1:0]       wr_index,
	input  logic [dpd_pkg::CFG_DATA_W-1:0]      wr_data
);

	dpd_pkg::cmd_t cmd;

	// Sequencer and handshake flags
	dpd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.in_ready  (sample.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cmd       (cmd)
	);

	// Arithmetic and state
	dpd_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.error    (sample.error),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.drive    (result.drive)
	);

endmodule
